// File: rtl/damped_string_wave_step_unit_macros.svh
// assertion macros for the damped string wave step unit
// used by rtl files that carry concurrent checks; expects clock and reset in scope
`ifndef DAMPED_STRING_WAVE_STEP_UNIT_MACROS_SVH
`define DAMPED_STRING_WAVE_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define DSW_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSW_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dsw_pkg.sv
// shared types, constants and fixed-point helpers of the damped string wave step unit
// no dependencies
package dsw_pkg;

   localparam int POINTS_DEF  = 64;
   localparam int DATA_W      = 16;
   localparam int COEF_W      = 16;
   localparam int IDX_OUT_W   = 6;
   localparam int CSR_IDX_W   = 2;
   localparam int OPND_W      = 18;
   localparam int PROD_W      = OPND_W + COEF_W + 1;
   localparam int ACC_W       = 37;
   localparam int FRAC_SHIFT  = 16;
   localparam int RND_W       = ACC_W - FRAC_SHIFT;
   localparam int SUM_W       = 22;
   localparam int ROUND_HALF  = 32768;

   localparam logic [COEF_W-1:0] SPRING_RST   = 16'd4096;
   localparam logic [COEF_W-1:0] DAMPING_RST  = 16'd256;
   localparam logic [COEF_W-1:0] POSITION_RST = 16'd4096;

   localparam logic signed [DATA_W-1:0] Q88_MAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] Q88_MIN = 16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPRING   = 2'd0,
      CSR_DAMPING  = 2'd1,
      CSR_POSITION = 2'd2
   } csr_idx_type;

   typedef enum logic {
      MAC_LOAD = 1'b0,
      MAC_SUB  = 1'b1
   } mac_op_type;

   typedef struct packed {
      logic              en;
      mac_op_type        op;
      logic [OPND_W-1:0] operand;
      logic [COEF_W-1:0] coef;
   } mac_ctrl_type;

   typedef struct packed {
      logic [COEF_W-1:0] spring;
      logic [COEF_W-1:0] damping;
      logic [COEF_W-1:0] position;
   } coef_type;

   // q.24 to q.8, round half up (floor after adding half)
   function automatic logic signed [RND_W-1:0] rnd_q24(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = x + ACC_W'(ROUND_HALF);
      return t[ACC_W-1:FRAC_SHIFT];
   endfunction

   // clamp to signed q8.8
   function automatic logic signed [DATA_W-1:0] sat_q88(input logic signed [SUM_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > SUM_W'(Q88_MAX)) begin
         r = Q88_MAX;
      end else if (x < SUM_W'(Q88_MIN)) begin
         r = Q88_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/dsw_req_if.sv
// input channel: one beat sets both end heights for a tick
// depends on dsw_pkg
interface dsw_req_if;
   import dsw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] left_end;
   logic signed [DATA_W-1:0] right_end;

   modport source(output valid, left_end, right_end, input ready);
   modport sink(input valid, left_end, right_end, output ready);
endinterface

// File: rtl/dsw_rsp_if.sv
// result channel: one beat per string point
// depends on dsw_pkg
interface dsw_rsp_if;
   import dsw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [IDX_OUT_W-1:0]     point_index;
   logic signed [DATA_W-1:0] height;
   logic                     last;

   modport source(output valid, point_index, height, last, input ready);
   modport sink(input valid, point_index, height, last, output ready);
endinterface

// File: rtl/dsw_csr_if.sv
// configuration write channel: register index and write data
// depends on dsw_pkg
interface dsw_csr_if;
   import dsw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/dsw_mac.sv
// shared multiply-accumulate unit: signed operand times unsigned q0.16 coefficient
// depends on dsw_pkg
module dsw_mac (
   input  logic                        clock,
   input  dsw_pkg::mac_ctrl_type       mac_ctrl,
   output logic signed [dsw_pkg::ACC_W-1:0] acc
);
   import dsw_pkg::*;

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod = $signed(mac_ctrl.operand) * $signed({1'b0, mac_ctrl.coef});

   always_comb begin
      case (mac_ctrl.op)
         MAC_LOAD: acc_in = ACC_W'(prod);
         MAC_SUB:  acc_in = acc_ff - ACC_W'(prod);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mac_ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

// File: rtl/dsw_core.sv
// sequencer, height and velocity memories, neighbor window and result register
// depends on dsw_pkg, dsw_req_if, dsw_rsp_if and the assertion macros; drives the shared dsw_mac unit through its ports
`include "damped_string_wave_step_unit_macros.svh"
module dsw_core #(
   parameter int POINTS = dsw_pkg::POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   dsw_req_if.sink                          req_bus,
   dsw_rsp_if.source                        rsp_bus,
   input  dsw_pkg::coef_type                coef,
   output dsw_pkg::mac_ctrl_type            mac_ctrl,
   input  logic signed [dsw_pkg::ACC_W-1:0] acc
);
   import dsw_pkg::*;

   localparam int IDX_W = $clog2(POINTS);

   typedef enum logic [9:0] {
      ST_CLEAR  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_PRIME  = 10'b0000000100,
      ST_LOAD   = 10'b0000001000,
      ST_SPRING = 10'b0000010000,
      ST_DAMP   = 10'b0000100000,
      ST_VEL    = 10'b0001000000,
      ST_POS    = 10'b0010000000,
      ST_HGT    = 10'b0100000000,
      ST_RIGHT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic signed [DATA_W-1:0] h_mem_ff [POINTS];
   logic signed [DATA_W-1:0] v_mem_ff [POINTS];
   logic signed [DATA_W-1:0] h_rd_ff, v_rd_ff;

   logic signed [DATA_W-1:0] h_l_ff, h_l_in;
   logic signed [DATA_W-1:0] h_c_ff, h_c_in;
   logic signed [DATA_W-1:0] h_r_ff, h_r_in;
   logic signed [DATA_W-1:0] right_ff, right_in;
   logic signed [DATA_W-1:0] newv_ff, newv_in;

   logic                     out_valid_ff;
   logic [IDX_OUT_W-1:0]     out_idx_ff;
   logic signed [DATA_W-1:0] out_h_ff;
   logic                     out_last_ff;

   logic                     out_free;
   logic                     out_load;
   logic [IDX_OUT_W-1:0]     out_idx_val;
   logic signed [DATA_W-1:0] out_h_val;
   logic                     out_last_val;

   logic                     h_we, v_we, rd_en, req_ready;
   logic [IDX_W-1:0]         h_raddr;
   logic signed [DATA_W-1:0] h_wdata, v_wdata;

   logic                     at_last_inner;
   logic signed [DATA_W-1:0] r_val;
   logic signed [OPND_W-1:0] lap;
   logic signed [DATA_W-1:0] newv;
   logic signed [DATA_W-1:0] hn;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign at_last_inner = (idx_ff == IDX_W'(POINTS - 2));
   // right neighbor of the last interior point is this tick's right end
   assign r_val = at_last_inner ? right_ff : h_rd_ff;
   assign lap   = OPND_W'(h_l_ff) + OPND_W'(r_val) - (OPND_W'(h_c_ff) <<< 1);
   assign newv  = sat_q88(SUM_W'(v_rd_ff) + SUM_W'(rnd_q24(acc)));
   assign hn    = sat_q88(SUM_W'(h_c_ff) + SUM_W'(rnd_q24(acc)));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      h_l_in       = h_l_ff;
      h_c_in       = h_c_ff;
      h_r_in       = h_r_ff;
      right_in     = right_ff;
      newv_in      = newv_ff;
      out_load     = 1'b0;
      out_idx_val  = IDX_OUT_W'(idx_ff);
      out_h_val    = hn;
      out_last_val = 1'b0;
      h_we         = 1'b0;
      h_wdata      = hn;
      v_we         = 1'b0;
      v_wdata      = newv;
      rd_en        = 1'b0;
      h_raddr      = idx_ff + IDX_W'(1);
      req_ready    = 1'b0;
      mac_ctrl     = '{en: 1'b0, op: MAC_LOAD, operand: lap, coef: coef.spring};
      case (state_ff)
         ST_CLEAR: begin
            h_we    = 1'b1;
            v_we    = 1'b1;
            h_wdata = '0;
            v_wdata = '0;
            idx_in  = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(POINTS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid) begin
               h_l_in   = req_bus.left_end;
               right_in = req_bus.right_end;
               idx_in   = IDX_W'(1);
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            rd_en   = 1'b1;
            h_raddr = idx_ff;
            if (out_free) begin
               out_load    = 1'b1;
               out_idx_val = '0;
               out_h_val   = h_l_ff;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rd_en = 1'b1;
            if (idx_ff == IDX_W'(1)) begin
               h_c_in = h_rd_ff;
            end
            state_in = ST_SPRING;
         end
         ST_SPRING: begin
            mac_ctrl = '{en: 1'b1, op: MAC_LOAD, operand: lap, coef: coef.spring};
            h_r_in   = r_val;
            state_in = ST_DAMP;
         end
         ST_DAMP: begin
            mac_ctrl = '{en: 1'b1, op: MAC_SUB, operand: OPND_W'(v_rd_ff),
                         coef: coef.damping};
            state_in = ST_VEL;
         end
         ST_VEL: begin
            newv_in  = newv;
            v_we     = 1'b1;
            state_in = ST_POS;
         end
         ST_POS: begin
            mac_ctrl = '{en: 1'b1, op: MAC_LOAD, operand: OPND_W'(newv_ff),
                         coef: coef.position};
            state_in = ST_HGT;
         end
         ST_HGT: begin
            if (out_free) begin
               h_we     = 1'b1;
               out_load = 1'b1;
               h_l_in   = h_c_ff;
               h_c_in   = h_r_ff;
               if (at_last_inner) begin
                  state_in = ST_RIGHT;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_RIGHT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_idx_val  = IDX_OUT_W'(POINTS - 1);
               out_h_val    = right_ff;
               out_last_val = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_l_ff   <= h_l_in;
      h_c_ff   <= h_c_in;
      h_r_ff   <= h_r_in;
      right_ff <= right_in;
      newv_ff  <= newv_in;
      if (out_load) begin
         out_idx_ff  <= out_idx_val;
         out_h_ff    <= out_h_val;
         out_last_ff <= out_last_val;
      end
   end

   // state memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (h_we) begin
         h_mem_ff[idx_ff] <= h_wdata;
      end
      if (v_we) begin
         v_mem_ff[idx_ff] <= v_wdata;
      end
      if (rd_en) begin
         h_rd_ff <= h_mem_ff[h_raddr];
         v_rd_ff <= v_mem_ff[idx_ff];
      end
   end

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.point_index = out_idx_ff;
   assign rsp_bus.height      = out_h_ff;
   assign rsp_bus.last        = out_last_ff;

   `DSW_ASSERT_NXT(a_accept_starts_tick, req_bus.valid && req_bus.ready, state_ff == ST_PRIME, "accepted tick did not start")
   `DSW_ASSERT_IMP(a_last_index, rsp_bus.valid && rsp_bus.last, rsp_bus.point_index == IDX_OUT_W'(POINTS - 1), "last beat on wrong point")
   `DSW_ASSERT_IMP(a_no_beat_in_clear, state_ff == ST_CLEAR, !rsp_bus.valid, "result beat during clearing pass")
   `DSW_ASSERT_IMP(a_mac_steps, mac_ctrl.en, state_ff == ST_SPRING || state_ff == ST_DAMP || state_ff == ST_POS, "mac used outside its steps")
endmodule

// File: rtl/damped_string_wave_step_unit.sv
// first beat (point 0) is loaded in ST_PRIME after acceptance, once output is free
// ticks do not overlap: the next is taken in ST_IDLE once the last beat is loaded;
// each interior point runs a six-step sequence around the one shared multiplier
// reset: synchronous, active high; coefficients return to their reset values and a
//   clearing pass zeroes every height and velocity before input is taken
module damped_string_wave_step_unit #(
   parameter int POINTS = dsw_pkg::POINTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dsw_req_if.sink    req_bus,
   dsw_rsp_if.source  rsp_bus,
   dsw_csr_if.sink    csr_bus
);
   import dsw_pkg::*;

   // coefficient registers, to be written only while the string is idle, unchecked
   coef_type     coef_ff;
   mac_ctrl_type mac_ctrl;
   logic signed [ACC_W-1:0] acc;

   // configuration beats are always taken; unknown indexes are dropped
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{spring: SPRING_RST, damping: DAMPING_RST, position: POSITION_RST};
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SPRING:   coef_ff.spring   <= csr_bus.data;
            CSR_DAMPING:  coef_ff.damping  <= csr_bus.data;
            CSR_POSITION: coef_ff.position <= csr_bus.data;
            default:      coef_ff          <= coef_ff;
         endcase
      end
   end

   // sequencer walks the points: load, spring product, damping product,
   // velocity update, position product, height update and beat out
   dsw_core #(
      .POINTS(POINTS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .coef     (coef_ff),
      .mac_ctrl (mac_ctrl),
      .acc      (acc)
   );

   // the one multiply-accumulate shared by all three products
   dsw_mac u_mac (
      .clock    (clock),
      .mac_ctrl (mac_ctrl),
      .acc      (acc)
   );
endmodule

// File: tb/damped_string_wave_step_unit_tb.sv
// self-checking testbench for damped_string_wave_step_unit: directed rows, then random end heights
// predicts every point height in a fixed-point string model of its own; depends on dsw_pkg
// and the dsw_req_if, dsw_rsp_if and dsw_csr_if interfaces
module damped_string_wave_step_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsw_pkg::*;

   localparam int POINTS      = POINTS_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   // the block finishes a tick with its last beat; a short settle covers any stragglers
   localparam int SETTLE      = 12;
   localparam int SEG_ITEMS   = 69;
   localparam int HOLD_CYCLES = 1200;
   localparam int PRINT_CAP   = 40;

   // no register sits behind this index, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]     point;
      logic signed [DATA_W-1:0] height;
      logic                     last;
   } point_beat_t;

   // one directed tick: coefficients in force, end heights, and where it is obvious
   // the height every interior point must show
   typedef struct packed {
      logic [COEF_W-1:0]        spring;
      logic [COEF_W-1:0]        damping;
      logic [COEF_W-1:0]        position;
      logic signed [DATA_W-1:0] left;
      logic signed [DATA_W-1:0] right;
      logic                     typed;
      logic signed [DATA_W-1:0] interior;
   } tick_row_t;

   localparam int NUM_ROWS = 18;
   localparam tick_row_t DIRECTED [NUM_ROWS] = '{
      // flat string after reset stays flat
      '{16'd4096,  16'd256,   16'd4096,  16'sd0,      16'sd0,      1'b1, 16'sd0},
      // zero position coefficient freezes the interior, ends at opposite extremes
      '{16'd4096,  16'd256,   16'd0,     Q88_MAX,     Q88_MIN,     1'b1, 16'sd0},
      '{16'd4096,  16'd256,   16'd0,     Q88_MIN,     Q88_MAX,     1'b1, 16'sd0},
      // all coefficients zero, alternating bit patterns and then -1 and 1 on the ends
      '{16'd0,     16'd0,     16'd0,     16'sh5555,   16'shaaaa,   1'b1, 16'sd0},
      '{16'd0,     16'd0,     16'd0,     -16'sd1,     16'sd1,      1'b1, 16'sd0},
      // velocities built up above are released
      '{16'd0,     16'd0,     16'd65535, 16'sd0,      16'sd0,      1'b0, 16'sd0},
      // maximum tension, with and without friction: velocity and height saturation
      '{16'd65535, 16'd0,     16'd65535, Q88_MAX,     Q88_MAX,     1'b0, 16'sd0},
      '{16'd65535, 16'd0,     16'd65535, Q88_MIN,     Q88_MIN,     1'b0, 16'sd0},
      '{16'd65535, 16'd65535, 16'd65535, Q88_MAX,     Q88_MIN,     1'b0, 16'sd0},
      '{16'd65535, 16'd65535, 16'd65535, 16'sd0,      16'sd0,      1'b0, 16'sd0},
      // friction alone, then mixed coefficient sets
      '{16'd0,     16'd65535, 16'd65535, 16'sd0,      16'sd0,      1'b0, 16'sd0},
      '{16'd0,     16'd65535, 16'd0,     16'sd1,      -16'sd1,     1'b0, 16'sd0},
      '{16'd4096,  16'd256,   16'd4096,  16'sd256,    -16'sd256,   1'b0, 16'sd0},
      '{16'd4096,  16'd256,   16'd4096,  16'sh00ff,   16'shff00,   1'b0, 16'sd0},
      '{16'd32768, 16'd128,   16'd32768, 16'sh1234,   16'shedcb,   1'b0, 16'sd0},
      '{16'd4096,  16'd256,   16'd4096,  16'sd0,      16'sd0,      1'b0, 16'sd0},
      // velocities saturate while heights are frozen, then get released
      '{16'd65535, 16'd0,     16'd0,     Q88_MAX,     Q88_MIN,     1'b0, 16'sd0},
      '{16'd0,     16'd0,     16'd65535, 16'sd0,      16'sd0,      1'b0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   dsw_req_if req_bus();
   dsw_rsp_if rsp_bus();
   dsw_csr_if csr_bus();

   damped_string_wave_step_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // string model: coefficients as last written, heights and velocities in q8.8
   logic [COEF_W-1:0]        coef_spring   = SPRING_RST;
   logic [COEF_W-1:0]        coef_damping  = DAMPING_RST;
   logic [COEF_W-1:0]        coef_position = POSITION_RST;
   logic signed [DATA_W-1:0] str_height [POINTS] = '{default: '0};
   logic signed [DATA_W-1:0] str_vel    [POINTS] = '{default: '0};

   point_beat_t pending_points [$];
   point_beat_t head_point;
   int          mismatches   = 0;
   int          cycle_count  = 0;

   // idle odds in percent, sender and receiver
   int req_idle_pct = 25;
   int rsp_idle_pct = 81;

   // long receiver hold-off, requested once by the stimulus
   logic pressure_req    = 1'b0;
   logic pressure_served = 1'b0;
   int   hold_left       = 0;

   logic signed [DATA_W-1:0] walk_left  = '0;
   logic signed [DATA_W-1:0] walk_right = '0;

   // q.24 back to q.8: add half, floor shift
   function automatic longint round_q24(input longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_q88(input longint x);
      if (x > 32767) return Q88_MAX;
      if (x < -32768) return Q88_MIN;
      return DATA_W'(x);
   endfunction

   // one euler step; all interior forces use the heights as they stand after the
   // ends are set and before any interior point moves
   function automatic void advance_string(input logic signed [DATA_W-1:0] l,
                                          input logic signed [DATA_W-1:0] r);
      longint                   lap;
      longint                   frc;
      logic signed [DATA_W-1:0] nv [POINTS];
      str_height[0]        = l;
      str_height[POINTS-1] = r;
      str_vel[0]           = '0;
      str_vel[POINTS-1]    = '0;
      for (int i = 1; i < POINTS - 1; i++) begin
         lap = longint'(str_height[i-1]) + longint'(str_height[i+1])
               - 2 * longint'(str_height[i]);
         frc = longint'(coef_spring) * lap - longint'(coef_damping) * longint'(str_vel[i]);
         nv[i] = clamp_q88(longint'(str_vel[i]) + round_q24(frc));
      end
      for (int i = 1; i < POINTS - 1; i++) begin
         str_vel[i]    = nv[i];
         str_height[i] = clamp_q88(longint'(str_height[i])
                                   + round_q24(longint'(coef_position) * longint'(nv[i])));
      end
   endfunction

   // random end height: mostly a drifting drive, some full-range noise, some extremes
   function automatic logic signed [DATA_W-1:0] next_end(input logic signed [DATA_W-1:0] prev);
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 55) return clamp_q88(longint'(prev) + longint'($urandom_range(0, 4096)) - 2048);
      if (mode < 80) return DATA_W'($urandom);
      case ($urandom_range(0, 3))
         0:       return Q88_MAX;
         1:       return Q88_MIN;
         2:       return '0;
         default: return -16'sd1;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      if (mismatches < PRINT_CAP)
         $display("%0t ns: mismatch on %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // offer one tick, with a random gap in front; valid stays high after the beat
   // so back-to-back ticks never lower and raise it in the same step
   task automatic send_tick(input logic signed [DATA_W-1:0] l, input logic signed [DATA_W-1:0] r,
                            input logic typed, input logic signed [DATA_W-1:0] interior);
      point_beat_t pt;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.left_end  <= l;
      req_bus.right_end <= r;
      do @(posedge clock); while (!req_bus.ready);
      advance_string(l, r);
      for (int i = 0; i < POINTS; i++) begin
         pt.point  = IDX_OUT_W'(i);
         pt.last   = (i == POINTS - 1);
         pt.height = str_height[i];
         if (typed && i != 0 && i != POINTS - 1) pt.height = interior;
         pending_points.push_back(pt);
      end
   endtask

   // stop offering and let every pending point come out
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_SPRING:   coef_spring   = val;
         CSR_DAMPING:  coef_damping  = val;
         CSR_POSITION: coef_position = val;
         default: ;
      endcase
   endtask

   // coefficients only change with the block idle; a stray write to the unused
   // index goes first and must leave everything as it was
   task automatic apply_coefs(input logic [COEF_W-1:0] s, input logic [COEF_W-1:0] d,
                              input logic [COEF_W-1:0] p);
      wait_drained();
      write_coef(CSR_UNUSED, COEF_W'($urandom));
      write_coef(CSR_SPRING, s);
      write_coef(CSR_DAMPING, d);
      write_coef(CSR_POSITION, p);
      csr_bus.valid <= 1'b0;
   endtask

   // result sink: random backpressure, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (pressure_req && !pressure_served) begin
            hold_left       = HOLD_CYCLES;
            pressure_served = 1'b1;
            rsp_bus.ready   <= 1'b0;
         end else begin
            rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // every accepted point beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            note_mismatch("beat with nothing pending, point_index", rsp_bus.point_index, -1);
         end else begin
            head_point = pending_points.pop_front();
            if (rsp_bus.point_index !== head_point.point)
               note_mismatch("point_index", rsp_bus.point_index, head_point.point);
            if (rsp_bus.height !== head_point.height)
               note_mismatch($sformatf("height of point %0d", head_point.point),
                             rsp_bus.height, head_point.height);
            if (rsp_bus.last !== head_point.last)
               note_mismatch($sformatf("last of point %0d", head_point.point),
                             rsp_bus.last, head_point.last);
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL damped_string_wave_step_unit");
      $finish;
   end

   initial begin
      logic [COEF_W-1:0] s;
      logic [COEF_W-1:0] d;
      logic [COEF_W-1:0] p;

      req_bus.valid     <= 1'b0;
      req_bus.left_end  <= '0;
      req_bus.right_end <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_SPRING;
      csr_bus.data      <= '0;

      // the block clears its point memory after reset and holds off input until done;
      // the handshake covers that
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows; coefficients are rewritten only when a row changes them
      for (int k = 0; k < NUM_ROWS; k++) begin
         if (DIRECTED[k].spring != coef_spring || DIRECTED[k].damping != coef_damping ||
             DIRECTED[k].position != coef_position)
            apply_coefs(DIRECTED[k].spring, DIRECTED[k].damping, DIRECTED[k].position);
         send_tick(DIRECTED[k].left, DIRECTED[k].right, DIRECTED[k].typed,
                   DIRECTED[k].interior);
      end

      // random segments: two with a slow receiver, two with a slow sender,
      // two with no idling at all
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            1: begin
               // everything at full scale
               s = '1; d = '1; p = '1;
            end
            2: begin
               s = COEF_W'($urandom); d = COEF_W'($urandom); p = COEF_W'($urandom);
            end
            3: begin
               // each coefficient at one extreme or the other
               s = $urandom_range(0, 1) ? '1 : '0;
               d = $urandom_range(0, 1) ? '1 : '0;
               p = $urandom_range(0, 1) ? '1 : '0;
            end
            5: begin
               s = SPRING_RST; d = DAMPING_RST; p = POSITION_RST;
            end
            default: begin
               // a string that mostly stays in range
               s = COEF_W'($urandom_range(0, 16384));
               d = COEF_W'($urandom_range(0, 4096));
               p = COEF_W'($urandom_range(0, 16384));
            end
         endcase
         apply_coefs(s, d, p);
         req_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 81 : 0;
         rsp_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 25 : 0;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // receiver stops dead while ticks keep coming, so the block backs up
            if (seg == 5 && n == 10) pressure_req <= 1'b1;
            walk_left  = next_end(walk_left);
            walk_right = next_end(walk_right);
            send_tick(walk_left, walk_right, 1'b0, '0);
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("PASS damped_string_wave_step_unit");
      end else begin
         $display("FAIL damped_string_wave_step_unit");
      end
      $finish;
   end

endmodule

// File: damped_string_wave_step_unit.f
+incdir+rtl
rtl/dsw_pkg.sv
rtl/dsw_req_if.sv
rtl/dsw_rsp_if.sv
rtl/dsw_csr_if.sv
rtl/dsw_mac.sv
rtl/dsw_core.sv
rtl/damped_string_wave_step_unit.sv
tb/damped_string_wave_step_unit_tb.sv
